/* sv/rslm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rslm_pkg
// Shared types and constants for the range smoother / LED mapper.
// ----------------------------------------------------------------------------
package rslm_pkg;

  localparam int RANGE_W     = 13;
  localparam int THR_W       = 8;
  localparam int DIV_W       = 8;
  localparam int STATIC_LEDS = 16;
  localparam int POV_STEPS   = 64;
  localparam int SPOS_W      = $clog2(STATIC_LEDS);
  localparam int PPOS_W      = $clog2(POV_STEPS);
  // 9*level + sample fits in 17 bits
  localparam int DVD_W       = RANGE_W + 4;
  localparam int CNT_W       = $clog2(DVD_W);

  // floor(x / 10) = (x * 52429) >> 19, exact for x below 2**18
  localparam int                RECIP_W      = 16;
  localparam logic [RECIP_W-1:0] SMOOTH_RECIP = 16'd52429;
  localparam int                RECIP_SHIFT  = 19;
  localparam int                PROD_W       = DVD_W + RECIP_W;

  localparam int IN_TDATA_W   = 16;
  localparam int IN_TUSER_W   = 3;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_TUSER_W  = 1;
  localparam int CFG_IDX_W    = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAT_DIV  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POV_DIV   = 2'd3;

  // sound commands
  localparam logic [1:0] SND_NONE = 2'd0;
  localparam logic [1:0] SND_ON   = 2'd1;
  localparam logic [1:0] SND_OFF  = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0]   jump_threshold;
    logic [RANGE_W-1:0] range_limit;
    logic [DIV_W-1:0]   static_divisor;
    logic [DIV_W-1:0]   pov_divisor;
  } rslm_cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } rslm_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } rslm_div_rsp_t;

endpackage

/* sv/rslm_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rslm_cfg
// Configuration register file, written through an indexed write channel.
// ----------------------------------------------------------------------------
module rslm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rslm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rslm_pkg::RANGE_W-1:0]   cfg_data,
  output rslm_pkg::rslm_cfg_t            cfg
);
  import rslm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jump_threshold <= THR_W'(3);
      cfg.range_limit    <= RANGE_W'(1300);
      cfg.static_divisor <= DIV_W'(20);
      cfg.pov_divisor    <= DIV_W'(10);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_JUMP_THR:  cfg.jump_threshold <= cfg_data[THR_W-1:0];
        REG_RANGE_LIM: cfg.range_limit    <= cfg_data;
        REG_STAT_DIV:  cfg.static_divisor <= cfg_data[DIV_W-1:0];
        REG_POV_DIV:   cfg.pov_divisor    <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/rslm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rslm_div
// Shared restoring divider, one quotient bit per cycle. A zero divisor acts
// as one.
// ----------------------------------------------------------------------------
module rslm_div (
  input  logic                    clk,
  input  logic                    rst,
  input  rslm_pkg::rslm_div_req_t req,
  output rslm_pkg::rslm_div_rsp_t rsp
);
  import rslm_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [DVD_W-1:0] quo;
  logic [DIV_W:0]   trial;

  assign trial = {rem, quo[DVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= (req.divisor == '0) ? DIV_W'(1) : req.divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= DIV_W'(trial - {1'b0, dsr});
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* sv/range_smoother_led_mapper_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_smoother_led_mapper_unit
// Smooths valid range samples and maps each new level to sound, LED map and
// spinning display index. One shared divider does both LED divisions; the
// smoothing divide by ten is a reciprocal multiply.
// ----------------------------------------------------------------------------
// Sequencing: an invalid sample is taken in idle and dropped; a level that emits nothing
//   returns from ST_CHECK to idle. An emitting level passes ST_CHECK, two passes of the
//   shared divider (ST_STAT, ST_POV) and ST_EMIT; a smoothed sample first passes ST_SMOOTH.
// Throughput: one item at a time; in_tready is low until the item finishes,
//   so an emitting item holds off new input through any wait on out_tready.
// Reset: synchronous; state, level history and configuration registers return to defaults.
module range_smoother_led_mapper_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rslm_pkg::IN_TDATA_W-1:0]  in_tdata,   // [12:0] range_mm
  input  logic [rslm_pkg::IN_TUSER_W-1:0]  in_tuser,   // [0] range_ok, [1] cap_mode_active,
                                                        // [2] static_mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rslm_pkg::OUT_TDATA_W-1:0] out_tdata,  // [12:0] level_mm, [14:13] sound_cmd,
                                                        // [30:15] static_led_map,
                                                        // [36:31] pov_index
  output logic [rslm_pkg::OUT_TUSER_W-1:0] out_tuser,  // [0] static_map_valid
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rslm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rslm_pkg::RANGE_W-1:0]     cfg_data
);
  import rslm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SMOOTH = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_STAT   = 3'd3;
  localparam logic [2:0] ST_POV    = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  rslm_cfg_t     cfg;
  rslm_div_req_t div_req;
  rslm_div_rsp_t div_rsp;

  logic [2:0]          state;
  logic [RANGE_W-1:0]  smoothed;
  logic                have_first;
  logic [RANGE_W-1:0]  last_emitted;
  logic                cap, stat;
  logic [RANGE_W-1:0]  level;
  logic [1:0]          sound;
  logic [SPOS_W-1:0]   spos;
  logic [PPOS_W-1:0]   ppos;
  logic                div_start;
  logic [DVD_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;

  logic [RANGE_W-1:0]  sample;
  logic [RANGE_W-1:0]  diff;
  logic                replace;
  logic [DVD_W-1:0]    blend;
  logic [PROD_W-1:0]   smooth_prod;
  logic                over;
  logic [RANGE_W-1:0]  clamped;
  logic [STATIC_LEDS-1:0] led_map;

  rslm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rslm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign div_req = {div_start, div_dividend, div_divisor};

  assign sample  = in_tdata[RANGE_W-1:0];
  assign diff    = (smoothed > sample) ? smoothed - sample : sample - smoothed;
  assign replace = !have_first || (diff > {{(RANGE_W-THR_W){1'b0}}, cfg.jump_threshold});
  // 9*level + sample without a multiplier
  assign blend   = {smoothed, 3'b000} + {4'b0000, smoothed} + {4'b0000, sample};
  // registered blend times the reciprocal of ten
  assign smooth_prod = PROD_W'(div_dividend) * PROD_W'(SMOOTH_RECIP);
  assign over    = smoothed > cfg.range_limit;
  assign clamped = over ? cfg.range_limit : smoothed;
  assign led_map = STATIC_LEDS'(1) << spos;

  assign in_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      smoothed      <= '0;
      have_first    <= 1'b0;
      last_emitted  <= '0;
      out_tvalid    <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      div_start <= (state == ST_CHECK && smoothed != last_emitted) ||
                   (state == ST_STAT && div_rsp.done);
      if (state == ST_EMIT && (!out_tvalid || out_tready)) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_tvalid && in_tuser[0]) begin
            have_first <= 1'b1;
            if (replace) begin
              smoothed <= sample;
              state    <= ST_CHECK;
            end else begin
              state    <= ST_SMOOTH;
            end
          end
        end
        ST_SMOOTH: begin
          smoothed <= smooth_prod[RECIP_SHIFT +: RANGE_W];
          state    <= ST_CHECK;
        end
        ST_CHECK: begin
          if (smoothed == last_emitted) begin
            state <= ST_IDLE;
          end else begin
            last_emitted <= clamped;
            state        <= ST_STAT;
          end
        end
        ST_STAT: begin
          if (div_rsp.done) begin
            state <= ST_POV;
          end
        end
        ST_POV: begin
          if (div_rsp.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_tvalid || out_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload side of the sequencer
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_tvalid) begin
      cap  <= in_tuser[1];
      stat <= in_tuser[2];
    end
    if (state == ST_IDLE) begin
      div_dividend <= blend;
    end
    if (state == ST_CHECK) begin
      level        <= clamped;
      sound        <= over ? (cap ? SND_NONE : SND_OFF) : SND_ON;
      div_dividend <= {{(DVD_W-RANGE_W){1'b0}}, clamped};
      div_divisor  <= cfg.static_divisor;
    end
    if (state == ST_STAT && div_rsp.done) begin
      spos        <= SPOS_W'(div_rsp.quotient % DVD_W'(STATIC_LEDS));
      div_divisor <= cfg.pov_divisor;
    end
    if (state == ST_POV && div_rsp.done) begin
      ppos <= PPOS_W'(div_rsp.quotient % DVD_W'(POV_STEPS));
    end
    if (state == ST_EMIT && (!out_tvalid || out_tready)) begin
      out_tdata[12:0]  <= level;
      out_tdata[14:13] <= sound;
      out_tdata[30:15] <= stat ? led_map : '0;
      out_tdata[36:31] <= ppos;
      out_tdata[39:37] <= '0;
      out_tuser[0]     <= stat;
    end
  end

`ifndef SYNTHESIS
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_STAT || state == ST_POV))
    else $error("divider result with no consumer");

  a_map_onehot: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> $onehot0(out_tdata[30:15]))
    else $error("static LED map not one-hot");

  a_sound_code: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> (out_tdata[14:13] != 2'd3))
    else $error("bad sound command");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && (!out_tvalid || out_tready)) |=> (out_tvalid && in_tready))
    else $error("result beat not loaded");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for range_smoother_led_mapper_unit. A local model of the
// smoother and the LED/POV mapper predicts each result beat when an input beat
// is taken. A monitor matches output beats, field by field, against those
// predictions in order. Both stream sides idle at random. The registers are
// reprogrammed between phases, including their extreme settings.
// ----------------------------------------------------------------------------
module testbench;
  import rslm_pkg::*;

  localparam int SETTLE_CYCLES = 80;   // covers the worst-case item latency
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic [RANGE_W-1:0]     level;
    logic [1:0]             sound;
    logic [STATIC_LEDS-1:0] map;
    logic                   map_valid;
    logic [PPOS_W-1:0]      pov;
  } led_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [12:0] range_mm
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // [0] range_ok, [1] cap_mode_active, [2] static_mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [12:0] level_mm, [14:13] sound_cmd,
                                           // [30:15] static_led_map, [36:31] pov_index
  logic [OUT_TUSER_W-1:0] out_tuser;       // [0] static_map_valid
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [RANGE_W-1:0]     cfg_data = '0;

  range_smoother_led_mapper_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model registers and state
  int thr_r, lim_r, sdiv_r, pdiv_r;
  int smooth_lvl, last_out;
  bit seen_first;

  led_result_t level_q[$];
  int  err_count   = 0;
  int  sent_total  = 0;
  int  sent_valid  = 0;
  int  res_count   = 0;
  int  settings    = 0;
  bit  bursty      = 1'b1;   // 0: both sides run without gaps
  bit  hold_req    = 1'b0;

  function automatic bit smooth_and_map(input logic [RANGE_W-1:0] mm, input bit ok,
                                        input bit cap, input bit stat,
                                        output led_result_t r);
    int s, diff, lvl, sd, pd;
    r = '0;
    if (!ok) return 1'b0;
    s = int'(mm);
    diff = (smooth_lvl > s) ? smooth_lvl - s : s - smooth_lvl;
    if (!seen_first || diff > thr_r) smooth_lvl = s;
    else smooth_lvl = (9 * smooth_lvl + s) / 10;
    seen_first = 1'b1;
    if (smooth_lvl == last_out) return 1'b0;
    lvl = smooth_lvl;
    if (lvl > lim_r) begin
      r.sound = cap ? SND_NONE : SND_OFF;
      lvl = lim_r;
    end else begin
      r.sound = SND_ON;
    end
    last_out = lvl;
    sd = (sdiv_r == 0) ? 1 : sdiv_r;
    pd = (pdiv_r == 0) ? 1 : pdiv_r;
    r.level     = lvl[RANGE_W-1:0];
    r.map       = stat ? (STATIC_LEDS'(1) << ((lvl / sd) % STATIC_LEDS)) : '0;
    r.map_valid = stat;
    r.pov       = PPOS_W'((lvl / pd) % POV_STEPS);
    return 1'b1;
  endfunction

  task automatic send_sample(input int mm, input bit ok, input bit cap, input bit stat);
    int gap;
    led_result_t r;
    gap = bursty ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-RANGE_W){1'b0}}, mm[RANGE_W-1:0]};
    in_tuser  <= {stat, cap, ok};
    do @(posedge clk); while (!in_tready);
    if (smooth_and_map(mm[RANGE_W-1:0], ok, cap, stat, r)) level_q.push_back(r);
    sent_total++;
    if (ok) sent_valid++;
  endtask

  // stop offering, let every result come back, then let the block go idle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int thr, input int lim, input int sdiv, input int pdiv);
    logic [RANGE_W-1:0]   vals [4];
    logic [CFG_IDX_W-1:0] ids  [4];
    vals = '{thr[RANGE_W-1:0], lim[RANGE_W-1:0], sdiv[RANGE_W-1:0], pdiv[RANGE_W-1:0]};
    ids  = '{REG_JUMP_THR, REG_RANGE_LIM, REG_STAT_DIV, REG_POV_DIV};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ids[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (ids[i])
        REG_JUMP_THR:  thr_r  = int'(vals[i][THR_W-1:0]);
        REG_RANGE_LIM: lim_r  = int'(vals[i]);
        REG_STAT_DIV:  sdiv_r = int'(vals[i][DIV_W-1:0]);
        REG_POV_DIV:   pdiv_r = int'(vals[i][DIV_W-1:0]);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    led_result_t e;
    if (!rst && out_tvalid && out_tready) begin
      res_count++;
      if (level_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got tdata 0x%0h tuser 0x%0h",
                 $time, out_tdata, out_tuser);
        err_count++;
      end else begin
        e = level_q.pop_front();
        check_field("level_mm",         e.level,     out_tdata[12:0]);
        check_field("sound_cmd",        e.sound,     out_tdata[14:13]);
        check_field("static_led_map",   e.map,       out_tdata[30:15]);
        check_field("pov_index",        e.pov,       out_tdata[36:31]);
        check_field("static_map_valid", e.map_valid, out_tuser[0]);
      end
    end
  end

  // result sink: random stalls per beat, one long hold-off on request
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = bursty ? $urandom_range(0, 7) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // reset defaults: first zero sample, invalid samples, clamp with and without
  // cap mode, repeated emission above the limit, smoothing steps, map off/on
  task automatic test_defaults_directed();
    send_sample(0,    1, 0, 1);   // equals reset history, no beat
    send_sample(500,  0, 1, 1);   // invalid, ignored
    send_sample(8191, 1, 1, 1);   // above limit, cap mode holds sound
    send_sample(8191, 1, 0, 1);   // still above limit, emits again with sound off
    send_sample(1000, 1, 0, 0);   // jump down, map off
    send_sample(998,  1, 0, 1);   // smoothing step down
    send_sample(1002, 1, 1, 1);   // smoothing step that rounds to no change
    send_sample(1300, 1, 0, 1);   // jump to exactly the limit
    send_sample(1301, 1, 0, 1);
    send_sample(1310, 1, 0, 1);   // jump just over the limit
    send_sample(8191, 0, 1, 0);   // invalid with cap mode set and static mode clear
    send_sample(0,    1, 1, 1);   // back to zero
    send_sample(5,    1, 0, 1);
    quiesce();
  endtask

  task automatic test_register_extremes();
    program_regs(0, 8191, 1, 1);
    send_sample(8191, 1, 0, 1);
    send_sample(8190, 1, 1, 1);
    send_sample(4095, 1, 0, 1);
    send_sample(4095, 1, 0, 1);
    quiesce();
    program_regs(255, 0, 255, 255);
    send_sample(0,    1, 0, 1);
    send_sample(200,  1, 1, 1);
    send_sample(8191, 1, 0, 1);
    send_sample(7000, 1, 1, 0);
    quiesce();
    program_regs(3, 1300, 0, 0);  // zero divisors behave as one
    send_sample(1299, 1, 0, 1);
    send_sample(47,   1, 0, 1);
    send_sample(63,   1, 1, 1);
    send_sample(8000, 1, 0, 1);
    quiesce();
  endtask

  // sink holds off while the source keeps offering emitting samples
  task automatic test_output_backpressure();
    bursty = 1'b0;
    program_regs(3, 8191, 20, 10);
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) send_sample((i % 2) ? 4000 + i : 100 + i, 1, i[1], i[2]);
    quiesce();
    bursty = 1'b1;
  endtask

  // source pauses until every pending result has come back
  task automatic test_drain_pause();
    for (int n = 0; n < 3; n++) begin
      for (int i = 0; i < 6; i++) begin
        send_sample($urandom_range(0, 8191), 1, 1'($urandom), 1'($urandom));
      end
      in_tvalid <= 1'b0;
      while (level_q.size() != 0) @(posedge clk);
    end
    quiesce();
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 15);
      default: return $urandom_range(0, 8191);   // upper bits are dropped
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 8191;
      2:       return 1300;
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  function automatic int pick_divisor();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return 255;
      3:       return $urandom_range(0, 8191);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // mostly samples near the current level so the smoothing path is exercised
  task automatic test_random_phases();
    int valid_cnt, mm, span, kind;
    for (int ph = 0; ph < 10; ph++) begin
      bursty = (ph % 3) != 2;
      program_regs(pick_threshold(), pick_limit(), pick_divisor(), pick_divisor());
      valid_cnt = 0;
      while (valid_cnt < 45) begin
        kind = $urandom_range(0, 99);
        span = thr_r + 3;
        if (kind < 65) begin
          mm = smooth_lvl + $urandom_range(0, 2 * span) - span;
        end else if (kind < 75) begin
          mm = lim_r + $urandom_range(0, 2 * span) - span;
        end else begin
          mm = $urandom_range(0, 8191);
        end
        if (mm < 0) mm = 0;
        if (mm > 8191) mm = 8191;
        if (kind >= 90) begin
          send_sample($urandom_range(0, 8191), 1'b0, 1'($urandom), 1'($urandom));
        end else begin
          send_sample(mm, 1'b1, 1'($urandom), 1'($urandom));
          valid_cnt++;
        end
      end
      quiesce();
    end
  endtask

  initial begin
    int waited;
    thr_r = 3; lim_r = 1300; sdiv_r = 20; pdiv_r = 10;
    smooth_lvl = 0; last_out = 0; seen_first = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults_directed();
    test_register_extremes();
    test_output_backpressure();
    test_drain_pause();
    test_random_phases();

    waited = 0;
    while (level_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (level_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived, first level %0d", $time,
               level_q.size(), level_q[0].level);
      err_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input beats (%0d valid samples), %0d result beats checked,",
             sent_total, sent_valid, res_count);
    $display("%0d register settings incl. extremes and zero divisors, %0d errors",
             settings, err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
